// File: design/ttut_pkg.sv
// shared types and constants for the tick timed uart transceiver
// no dependencies
`timescale 1ns / 1ps

package ttut_pkg;

   typedef enum logic [2:0] {
      RX_IDLE       = 3'd0,
      RX_START_QTR  = 3'd1,
      RX_START_HALF = 3'd2,
      RX_DATA       = 3'd3,
      RX_STOP       = 3'd4
   } rx_phase_type;

   localparam logic [7:0] TX_IDLE      = 8'd0;
   localparam logic [7:0] TX_LOAD      = 8'd1;
   localparam logic [7:0] TX_DATA      = 8'd2;
   localparam logic [7:0] TX_DATA_LAST = 8'd9;
   localparam logic [7:0] TX_STOP_BASE = 8'd99;
   localparam logic [7:0] TX_STOP      = 8'd100;
   localparam logic [7:0] TX_DONE      = 8'd255;

   localparam int unsigned CSR_ADDR_W = 5;

   localparam logic [2:0] CSR_DATA_BITS   = 3'd0;
   localparam logic [2:0] CSR_STOP_BITS   = 3'd1;
   localparam logic [2:0] CSR_BIT_PERIOD  = 3'd2;
   localparam logic [2:0] CSR_TX_INVERT   = 3'd3;
   localparam logic [2:0] CSR_RX_INVERT   = 3'd4;
   localparam logic [2:0] CSR_HALF_DUPLEX = 3'd5;
   localparam logic [2:0] CSR_ECHO_ENABLE = 3'd6;

endpackage

// File: design/tick_timed_uart_transceiver_top.sv
// tick timed uart transceiver: receiver, transmitter, csr block and result register
// depends on ttut_pkg
`timescale 1ns / 1ps

// Each req transfer is one timer tick carrying the sampled rx pin and an offered
// tx byte; each tick yields exactly one rsp transfer with the tx pin level, whether
// the offered byte was taken, any received character and the sticky framing flag.
// The receiver and transmitter state update at the req transfer and the result
// lands in a single output register, so one tick per cycle is sustained whenever
// rsp_ready keeps up. The user must write registers over the APB port only while
// no tick is in flight; the block itself does not enforce this.
module tick_timed_uart_transceiver_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_rx_line,
   input  logic        req_tx_valid,
   input  logic [7:0]  req_tx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_tx_line,
   output logic        rsp_tx_taken,
   output logic        rsp_rx_valid,
   output logic [7:0]  rsp_rx_byte,
   output logic        rsp_framing_error,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [ttut_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // configuration
   logic [3:0] data_bits_ff, stop_bits_ff;
   logic [7:0] bit_period_ff;
   logic [1:0] tx_invert_ff, rx_invert_ff;
   logic       half_duplex_ff, echo_enable_ff;

   // state
   ttut_pkg::rx_phase_type rx_phase_ff, rx_phase_in;
   logic [7:0] rx_countdown_ff, rx_countdown_in;
   logic [7:0] rx_shift_ff, rx_shift_in;
   logic [3:0] rx_bit_index_ff, rx_bit_index_in;
   logic       rx_on_ff, rx_on_in;
   logic [7:0] tx_phase_ff, tx_phase_in;
   logic [7:0] tx_countdown_ff, tx_countdown_in;
   logic [7:0] tx_shift_ff, tx_shift_in;
   logic       tx_on_ff, tx_on_in;
   logic       line_level_ff, line_level_in;
   logic       frame_flag_ff, frame_flag_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_tx_taken_ff, rsp_tx_taken_in;
   logic       rsp_rx_valid_ff, rsp_rx_valid_in;
   logic [7:0] rsp_rx_byte_ff, rsp_rx_byte_in;

   logic       req_accept;
   logic       csr_write;
   logic [2:0] csr_index;
   logic [3:0] db, sb;
   logic [2:0] db_msb;
   logic       pin;

   assign req_ready  = ~rsp_valid_ff | rsp_ready;
   assign req_accept = req_valid & req_ready;
   assign pready     = 1'b1;
   assign csr_index  = paddr[4:2];
   assign csr_write  = psel & penable & pwrite & pready;

   // csr write and read
   always_ff @(posedge clock) begin
      if (reset) begin
         data_bits_ff   <= 4'd8;
         stop_bits_ff   <= 4'd1;
         bit_period_ff  <= 8'd9;
         tx_invert_ff   <= 2'd0;
         rx_invert_ff   <= 2'd0;
         half_duplex_ff <= 1'b0;
         echo_enable_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            ttut_pkg::CSR_DATA_BITS:   data_bits_ff   <= pwdata[3:0];
            ttut_pkg::CSR_STOP_BITS:   stop_bits_ff   <= pwdata[3:0];
            ttut_pkg::CSR_BIT_PERIOD:  bit_period_ff  <= pwdata[7:0];
            ttut_pkg::CSR_TX_INVERT:   tx_invert_ff   <= pwdata[1:0];
            ttut_pkg::CSR_RX_INVERT:   rx_invert_ff   <= pwdata[1:0];
            ttut_pkg::CSR_HALF_DUPLEX: half_duplex_ff <= pwdata[0];
            ttut_pkg::CSR_ECHO_ENABLE: echo_enable_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         ttut_pkg::CSR_DATA_BITS:   prdata = {28'd0, data_bits_ff};
         ttut_pkg::CSR_STOP_BITS:   prdata = {28'd0, stop_bits_ff};
         ttut_pkg::CSR_BIT_PERIOD:  prdata = {24'd0, bit_period_ff};
         ttut_pkg::CSR_TX_INVERT:   prdata = {30'd0, tx_invert_ff};
         ttut_pkg::CSR_RX_INVERT:   prdata = {30'd0, rx_invert_ff};
         ttut_pkg::CSR_HALF_DUPLEX: prdata = {31'd0, half_duplex_ff};
         ttut_pkg::CSR_ECHO_ENABLE: prdata = {31'd0, echo_enable_ff};
         default:                   prdata = 32'd0;
      endcase
   end

   // effective framing
   always_comb begin
      if (data_bits_ff == 4'd0) begin
         db = 4'd1;
      end else if (data_bits_ff > 4'd8) begin
         db = 4'd8;
      end else begin
         db = data_bits_ff;
      end
      sb     = (stop_bits_ff == 4'd0) ? 4'd1 : stop_bits_ff;
      db_msb = 3'(db - 4'd1);
   end

   // one tick: countdowns, then receiver, then transmitter
   always_comb begin
      rx_phase_in     = rx_phase_ff;
      rx_countdown_in = (rx_countdown_ff != 8'd0) ? rx_countdown_ff - 8'd1 : rx_countdown_ff;
      rx_shift_in     = rx_shift_ff;
      rx_bit_index_in = rx_bit_index_ff;
      rx_on_in        = rx_on_ff;
      tx_phase_in     = tx_phase_ff;
      tx_countdown_in = (tx_countdown_ff != 8'd0) ? tx_countdown_ff - 8'd1 : tx_countdown_ff;
      tx_shift_in     = tx_shift_ff;
      tx_on_in        = tx_on_ff;
      line_level_in   = line_level_ff;
      frame_flag_in   = frame_flag_ff;
      rsp_tx_taken_in = 1'b0;
      rsp_rx_valid_in = 1'b0;
      rsp_rx_byte_in  = 8'd0;
      pin = req_rx_line ^ ((rx_phase_ff == ttut_pkg::RX_DATA) ? rx_invert_ff[0]
                                                             : rx_invert_ff[1]);

      if (rx_countdown_in == 8'd0 && rx_on_ff) begin
         case (rx_phase_ff)
            ttut_pkg::RX_IDLE: begin
               if (!pin) begin
                  rx_phase_in     = ttut_pkg::RX_START_QTR;
                  rx_countdown_in = bit_period_ff >> 2;
                  if (half_duplex_ff) tx_on_in = 1'b0;
               end
            end
            ttut_pkg::RX_START_QTR, ttut_pkg::RX_START_HALF: begin
               if (!pin) begin
                  if (rx_phase_ff == ttut_pkg::RX_START_QTR) begin
                     rx_phase_in     = ttut_pkg::RX_START_HALF;
                     rx_countdown_in = bit_period_ff >> 2;
                  end else begin
                     rx_phase_in     = ttut_pkg::RX_DATA;
                     rx_shift_in     = 8'd0;
                     rx_bit_index_in = 4'd0;
                     rx_countdown_in = bit_period_ff;
                  end
               end else begin
                  rx_phase_in = ttut_pkg::RX_IDLE;
                  if (half_duplex_ff) tx_on_in = 1'b1;
               end
            end
            ttut_pkg::RX_DATA: begin
               rx_shift_in = {1'b0, rx_shift_ff[7:1]};
               if (pin) rx_shift_in[db_msb] = 1'b1;
               rx_bit_index_in = rx_bit_index_ff + 4'd1;
               if (rx_bit_index_in >= db) rx_phase_in = ttut_pkg::RX_STOP;
               rx_countdown_in = bit_period_ff;
            end
            ttut_pkg::RX_STOP: begin
               if (!pin) begin
                  frame_flag_in   = 1'b1;
                  rx_countdown_in = bit_period_ff >> 3;
               end else begin
                  rsp_rx_valid_in = 1'b1;
                  rsp_rx_byte_in  = rx_shift_ff;
                  if (echo_enable_ff && tx_phase_ff == ttut_pkg::TX_IDLE) begin
                     tx_shift_in = rx_shift_ff;
                     tx_phase_in = ttut_pkg::TX_LOAD;
                  end
                  rx_phase_in = ttut_pkg::RX_IDLE;
                  if (half_duplex_ff) tx_on_in = 1'b1;
               end
            end
            default: rx_phase_in = ttut_pkg::RX_IDLE;
         endcase
      end

      if (tx_countdown_in == 8'd0 && tx_on_in) begin
         if (tx_phase_in == ttut_pkg::TX_IDLE) begin
            if (req_tx_valid) begin
               tx_shift_in     = req_tx_byte;
               rsp_tx_taken_in = 1'b1;
               if (half_duplex_ff) rx_on_in = 1'b0;
               tx_countdown_in = bit_period_ff;
               line_level_in   = ~tx_invert_ff[1];
               tx_phase_in     = ttut_pkg::TX_DATA;
            end
         end else if (tx_phase_in == ttut_pkg::TX_LOAD) begin
            tx_countdown_in = bit_period_ff;
            line_level_in   = ~tx_invert_ff[1];
            tx_phase_in     = ttut_pkg::TX_DATA;
         end else if (tx_phase_in inside {[ttut_pkg::TX_DATA:ttut_pkg::TX_DATA_LAST]}) begin
            tx_countdown_in = bit_period_ff;
            line_level_in   = tx_shift_in[0] ^ tx_invert_ff[0];
            tx_shift_in     = {1'b0, tx_shift_in[7:1]};
            if ((tx_phase_in - 8'd1) >= {4'd0, db}) begin
               tx_phase_in = ttut_pkg::TX_STOP;
            end else begin
               tx_phase_in = tx_phase_in + 8'd1;
            end
         end else if (tx_phase_in inside {[ttut_pkg::TX_STOP:ttut_pkg::TX_DONE - 8'd1]}) begin
            tx_countdown_in = bit_period_ff;
            line_level_in   = tx_invert_ff[1];
            if ((tx_phase_in - ttut_pkg::TX_STOP_BASE) >= {4'd0, sb}) begin
               tx_phase_in = ttut_pkg::TX_DONE;
            end else begin
               tx_phase_in = tx_phase_in + 8'd1;
            end
         end else begin
            // end of frame: chain the next byte straight into its start bit
            if (req_tx_valid) begin
               tx_shift_in     = req_tx_byte;
               rsp_tx_taken_in = 1'b1;
               tx_countdown_in = bit_period_ff;
               line_level_in   = ~tx_invert_ff[1];
               tx_phase_in     = ttut_pkg::TX_DATA;
            end else begin
               tx_phase_in = ttut_pkg::TX_IDLE;
               if (half_duplex_ff) rx_on_in = 1'b1;
            end
         end
      end

      rsp_valid_in = req_accept | (rsp_valid_ff & ~rsp_ready);
   end

   // state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_phase_ff     <= ttut_pkg::RX_IDLE;
         rx_countdown_ff <= 8'd0;
         rx_shift_ff     <= 8'd0;
         rx_bit_index_ff <= 4'd0;
         rx_on_ff        <= 1'b1;
         tx_phase_ff     <= ttut_pkg::TX_IDLE;
         tx_countdown_ff <= 8'd0;
         tx_shift_ff     <= 8'd0;
         tx_on_ff        <= 1'b1;
         line_level_ff   <= 1'b0;
         frame_flag_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            rx_phase_ff     <= rx_phase_in;
            rx_countdown_ff <= rx_countdown_in;
            rx_shift_ff     <= rx_shift_in;
            rx_bit_index_ff <= rx_bit_index_in;
            rx_on_ff        <= rx_on_in;
            tx_phase_ff     <= tx_phase_in;
            tx_countdown_ff <= tx_countdown_in;
            tx_shift_ff     <= tx_shift_in;
            tx_on_ff        <= tx_on_in;
            line_level_ff   <= line_level_in;
            frame_flag_ff   <= frame_flag_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_tx_taken_ff <= rsp_tx_taken_in;
         rsp_rx_valid_ff <= rsp_rx_valid_in;
         rsp_rx_byte_ff  <= rsp_rx_byte_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tx_line       = line_level_ff;
   assign rsp_tx_taken      = rsp_tx_taken_ff;
   assign rsp_rx_valid      = rsp_rx_valid_ff;
   assign rsp_rx_byte       = rsp_rx_byte_ff;
   assign rsp_framing_error = frame_flag_ff;

   // checks
   a_transfer_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted tick left no result");

   a_never_both_locked: assert property (@(posedge clock) disable iff (reset)
      rx_on_ff || tx_on_ff)
      else $error("receiver and transmitter both locked out");

   a_tx_phase_legal: assert property (@(posedge clock) disable iff (reset)
      tx_phase_ff <= ttut_pkg::TX_DATA_LAST || tx_phase_ff >= ttut_pkg::TX_STOP)
      else $error("transmit phase in unused range");

   a_rx_byte_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_rx_valid_ff |-> rsp_rx_byte_ff == 8'd0)
      else $error("rx byte nonzero without rx valid");

   a_rx_index_bound: assert property (@(posedge clock) disable iff (reset)
      rx_bit_index_ff <= 4'd8)
      else $error("receive bit index past eight");

endmodule
